[design/slx_pkg.sv]
// shared types, constants and character helpers for the script lexer
package slx_pkg;

	localparam int POS_WIDTH = 16;
	localparam int PREFIX_WIDTH = 48;
	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW = $clog2(RQ_DEPTH);

	localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

	typedef logic [POS_WIDTH-1:0] pos_t;

	typedef enum logic [2:0] {
		M_IDLE,
		M_IDENT,
		M_INT,
		M_EQ,
		M_BANG,
		M_ERR
	} lex_mode_t;

	typedef enum logic [4:0] {
		K_END, K_ERROR, K_IDENT, K_INT,
		K_VAR, K_IF, K_ELSE, K_WHILE, K_DEF, K_RETURN,
		K_EQEQ, K_NE, K_ASSIGN, K_LT, K_GT, K_PLUS, K_MINUS, K_STAR, K_SLASH,
		K_LPAREN, K_RPAREN, K_LBRACE, K_RBRACE, K_COMMA, K_COLON, K_SEMI
	} kind_t;

	typedef struct packed {
		lex_mode_t mode;
		pos_t pos;
		pos_t tstart;
		pos_t tlen;
		logic [PREFIX_WIDTH-1:0] prefix;
	} lex_state_t;

	typedef struct packed {
		kind_t kind;
		logic [15:0] start_pos;
		logic [15:0] token_len;
		logic last;
	} tok_t;

	// up to two tokens per character, in order
	typedef struct packed {
		logic [1:0] cnt;
		tok_t [1:0] tok;
	} tok_pair_t;

	typedef struct packed {
		logic valid;
		kind_t kind;
	} mark_t;

	function automatic pos_t sat_inc(pos_t v);
		return (v == POS_MAX) ? v : v + 1'b1;
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic mark_t mark_kind(logic [7:0] c);
		mark_t m;
		m.valid = 1'b1;
		case (c)
			"<": m.kind = K_LT;
			">": m.kind = K_GT;
			"+": m.kind = K_PLUS;
			"-": m.kind = K_MINUS;
			"*": m.kind = K_STAR;
			"/": m.kind = K_SLASH;
			"(": m.kind = K_LPAREN;
			")": m.kind = K_RPAREN;
			"{": m.kind = K_LBRACE;
			"}": m.kind = K_RBRACE;
			",": m.kind = K_COMMA;
			":": m.kind = K_COLON;
			";": m.kind = K_SEMI;
			default: begin
				m.valid = 1'b0;
				m.kind = K_ERROR;
			end
		endcase
		return m;
	endfunction

	// identifier kind from the packed first bytes and the length
	function automatic kind_t ident_kind(logic [PREFIX_WIDTH-1:0] p, pos_t len);
		kind_t k;
		k = K_IDENT;
		if (len == POS_WIDTH'(3) && p == PREFIX_WIDTH'("var"))
			k = K_VAR;
		else if (len == POS_WIDTH'(2) && p == PREFIX_WIDTH'("if"))
			k = K_IF;
		else if (len == POS_WIDTH'(4) && p == PREFIX_WIDTH'("else"))
			k = K_ELSE;
		else if (len == POS_WIDTH'(5) && p == PREFIX_WIDTH'("while"))
			k = K_WHILE;
		else if (len == POS_WIDTH'(3) && p == PREFIX_WIDTH'("def"))
			k = K_DEF;
		else if (len == POS_WIDTH'(6) && p == PREFIX_WIDTH'("return"))
			k = K_RETURN;
		return k;
	endfunction

	function automatic tok_t make_tok(kind_t k, pos_t start, pos_t len);
		tok_t t;
		t.kind = k;
		t.start_pos = 16'(start);
		t.token_len = 16'(len);
		t.last = 1'b0;
		return t;
	endfunction

	function automatic tok_pair_t push_tok(tok_pair_t p, tok_t t);
		tok_pair_t r;
		r = p;
		if (p.cnt == 2'd0) begin
			r.tok[0] = t;
			r.cnt = 2'd1;
		end else begin
			r.tok[1] = t;
			r.cnt = 2'd2;
		end
		return r;
	endfunction

endpackage

[design/slx_if.sv]
// stream interfaces for text bytes in and tokens out
interface slx_text_if;
	logic valid;
	logic ready;
	logic op;
	logic [7:0] ch;

	modport source (output valid, output op, output ch, input ready);
	modport sink (input valid, input op, input ch, output ready);
endinterface

interface slx_tok_if;
	logic valid;
	logic ready;
	logic [4:0] kind;
	logic [15:0] start_pos;
	logic [15:0] token_len;
	logic last;

	modport source (output valid, output kind, output start_pos, output token_len,
		output last, input ready);
	modport sink (input valid, input kind, input start_pos, input token_len,
		input last, output ready);
endinterface

[design/slx_step.sv]
// next lexer state and emitted tokens for one text beat
module slx_step (
	input  slx_pkg::lex_state_t cur,
	input  logic                op,
	input  logic [7:0]          ch,
	output slx_pkg::lex_state_t nxt,
	output slx_pkg::tok_pair_t  res
);
	import slx_pkg::*;

	logic flush_v;
	tok_t flush_tok;
	logic restart;
	mark_t mk;
	logic c_space, c_alpha, c_digit;

	assign c_space = is_space(ch);
	assign c_alpha = is_alpha(ch);
	assign c_digit = is_digit(ch);
	assign mk = mark_kind(ch);

	// pending token, if any
	always_comb begin
		flush_v = 1'b1;
		flush_tok = make_tok(K_ERROR, cur.tstart, cur.tlen);
		unique case (cur.mode)
			M_IDENT: flush_tok = make_tok(ident_kind(cur.prefix, cur.tlen), cur.tstart, cur.tlen);
			M_INT: flush_tok = make_tok(K_INT, cur.tstart, cur.tlen);
			M_EQ: flush_tok = make_tok(K_ASSIGN, cur.tstart, POS_WIDTH'(1));
			M_BANG, M_ERR: flush_tok = make_tok(K_ERROR, cur.tstart, cur.tlen);
			default: flush_v = 1'b0;
		endcase
	end

	always_comb begin
		nxt = cur;
		res = '0;
		restart = 1'b0;
		if (op) begin
			if (flush_v)
				res = push_tok(res, flush_tok);
			res = push_tok(res, make_tok(K_END, cur.pos, '0));
			nxt = '0;
			nxt.mode = M_IDLE;
		end else begin
			unique case (cur.mode)
				M_IDENT: begin
					if (c_alpha || c_digit) begin
						if (cur.tlen < POS_WIDTH'(6))
							nxt.prefix = {cur.prefix[PREFIX_WIDTH-9:0], ch};
						nxt.tlen = sat_inc(cur.tlen);
					end else begin
						res = push_tok(res, flush_tok);
						restart = 1'b1;
					end
				end
				M_INT: begin
					if (c_digit) begin
						nxt.tlen = sat_inc(cur.tlen);
					end else begin
						res = push_tok(res, flush_tok);
						restart = 1'b1;
					end
				end
				M_EQ: begin
					if (ch == "=") begin
						res = push_tok(res, make_tok(K_EQEQ, cur.tstart, POS_WIDTH'(2)));
						nxt.mode = M_IDLE;
					end else begin
						res = push_tok(res, flush_tok);
						restart = 1'b1;
					end
				end
				M_BANG: begin
					if (ch == "=") begin
						res = push_tok(res, make_tok(K_NE, cur.tstart, POS_WIDTH'(2)));
						nxt.mode = M_IDLE;
					end else if (c_space) begin
						res = push_tok(res, flush_tok);
						nxt.mode = M_IDLE;
					end else begin
						nxt.tlen = sat_inc(cur.tlen);
						nxt.mode = M_ERR;
					end
				end
				M_ERR: begin
					if (c_space) begin
						res = push_tok(res, flush_tok);
						nxt.mode = M_IDLE;
					end else begin
						nxt.tlen = sat_inc(cur.tlen);
					end
				end
				default: restart = 1'b1;
			endcase

			// a character seen while between tokens
			if (restart) begin
				nxt.mode = M_IDLE;
				if (!c_space) begin
					nxt.tstart = cur.pos;
					nxt.tlen = POS_WIDTH'(1);
					nxt.prefix = PREFIX_WIDTH'(ch);
					if (c_alpha)
						nxt.mode = M_IDENT;
					else if (c_digit)
						nxt.mode = M_INT;
					else if (ch == "=")
						nxt.mode = M_EQ;
					else if (ch == "!")
						nxt.mode = M_BANG;
					else if (mk.valid)
						res = push_tok(res, make_tok(mk.kind, cur.pos, POS_WIDTH'(1)));
					else
						nxt.mode = M_ERR;
				end
			end
			nxt.pos = sat_inc(cur.pos);
		end

		if (res.cnt == 2'd2)
			res.tok[1].last = 1'b1;
		else if (res.cnt == 2'd1)
			res.tok[0].last = 1'b1;
	end

endmodule

[design/slx_fifo.sv]
// token queue: takes up to two tokens a cycle, gives one
module slx_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  slx_pkg::tok_pair_t    push,
	input  logic                  pop,
	output slx_pkg::tok_t         head,
	output logic                  nonempty,
	output logic                  room,
	output logic [slx_pkg::RQ_AW:0] count
);
	import slx_pkg::*;

	tok_t mem_q [RQ_DEPTH];
	logic [RQ_AW-1:0] wr_q, rd_q;
	logic [RQ_AW:0] cnt_q;
	logic [RQ_AW:0] cnt_after_pop;

	assign head = mem_q[rd_q];
	assign nonempty = cnt_q != '0;
	assign count = cnt_q;
	assign cnt_after_pop = cnt_q - {{RQ_AW{1'b0}}, pop};
	// room for two more beats, counting the one leaving now
	assign room = cnt_after_pop <= (RQ_AW+1)'(RQ_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0)
			mem_q[wr_q] <= push.tok[0];
		if (push.cnt == 2'd2)
			mem_q[wr_q + 1'b1] <= push.tok[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + RQ_AW'(push.cnt);
			if (pop)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_after_pop + (RQ_AW+1)'(push.cnt);
		end
	end

endmodule

[design/script_lexer_top.sv]
// script lexer top level: input stage, lexer step and token queue
// flow: a byte accepted into the input stage is lexed when it advances, which
//   needs room in the token queue; its tokens then enter the queue in order
// throughput: one byte per cycle while the token queue has room; the token port
//   moves one beat per cycle, so a byte that closes one token and emits another uses it in turn
// reset: lexer idle, positions zero, input stage and token queue empty
module script_lexer_top (
	input logic     clk,
	input logic     arst_n,
	slx_text_if.sink  text,
	slx_tok_if.source token
);
	import slx_pkg::*;

	logic valid_s1;
	logic op_s1;
	logic [7:0] ch_s1;
	logic adv;

	lex_state_t state_q, state_nxt;
	tok_pair_t step_res, push;
	tok_t head;
	logic q_nonempty, q_room, pop;
	logic [RQ_AW:0] q_count;

	assign pop = token.valid && token.ready;
	assign adv = valid_s1 && q_room;
	assign text.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.valid && text.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			op_s1 <= text.op;
			ch_s1 <= text.ch;
		end
	end

	slx_step u_step (
		.cur (state_q),
		.op  (op_s1),
		.ch  (ch_s1),
		.nxt (state_nxt),
		.res (step_res)
	);

	// all-zero state is idle with positions zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		push = step_res;
		if (!adv)
			push.cnt = 2'd0;
	end

	slx_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop      (pop),
		.head     (head),
		.nonempty (q_nonempty),
		.room     (q_room),
		.count    (q_count)
	);

	assign token.valid = q_nonempty;
	assign token.kind = head.kind;
	assign token.start_pos = head.start_pos;
	assign token.token_len = head.token_len;
	assign token.last = head.last;

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= (RQ_AW+1)'(RQ_DEPTH))
		else $error("token queue over depth");

	a_end_resets_pos: assert property (@(posedge clk) disable iff (!arst_n)
		adv && op_s1 |=> state_q.pos == '0 && state_q.mode == M_IDLE)
		else $error("end of text did not return lexer to start");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		token.valid && token.kind == K_END |-> token.last)
		else $error("end token without last");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(ch_s1) && $stable(op_s1))
		else $error("stalled input stage changed");

endmodule
